// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the glyph locator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/glb_pkg.sv =====
// ----------------------------------------------------------------------------
// glb_pkg
// Types, codes and constants shared by the glyph locator modules.
// ----------------------------------------------------------------------------
package glb_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 4096;

	localparam int unsigned CP_W     = 21;
	localparam int unsigned SLOT_W   = 12;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned OFFSET_W = 20;
	localparam int unsigned WIDTH_W  = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned ASCII_CNT_W = 9;
	localparam int unsigned WIDE_CNT_W  = 13;

	localparam logic [0:0] REQ_WRITE  = 1'b0;
	localparam logic [0:0] REQ_LOOKUP = 1'b1;

	localparam logic [KIND_W-1:0] KIND_NONE        = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CONTROL     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ASCII       = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REPLACEMENT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WIDE        = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ASCII_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_LOADED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_STRIDE = 3'd4;

	localparam logic [CP_W-1:0] CONTROL_LIMIT  = 21'h00020;
	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h0FFFD;

	localparam logic [WIDTH_W-1:0] NARROW_WIDTH      = 8'd8;
	localparam logic [WIDTH_W-1:0] REPLACEMENT_WIDTH = 8'd16;

	localparam logic [ASCII_CNT_W-1:0] ASCII_COUNT_RST = 9'd128;
	localparam logic [WIDTH_W-1:0]     WIDE_WIDTH_RST  = 8'd16;
	localparam logic [7:0]             WIDE_STRIDE_RST = 8'd32;

	typedef struct packed {
		logic [0:0]        req_type;
		logic [SLOT_W-1:0] entry_slot;
		logic [CP_W-1:0]   entry_codepoint;
		logic [CP_W-1:0]   query_codepoint;
	} req_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]   glyph_kind;
		logic [OFFSET_W-1:0] glyph_offset;
		logic [WIDTH_W-1:0]  glyph_px;
	} rsp_item_t;

	typedef struct packed {
		logic wr;
		logic load;
		logic step;
		logic scale;
		logic emit;
	} glb_cmd_t;

	typedef struct packed {
		logic need_search;
		logic search_done;
		logic hit;
		logic rsp_free;
	} glb_status_t;

endpackage

// ===== rtl/core/glyph_locator_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// glyph_locator_binary_search_top
// Classifies codepoints and binary-searches a sorted wide-font table.
//
//   Channel   Handshake               Payload
//   req       req_valid / req_stall   glb_pkg::req_item_t (write or lookup)
//   rsp       rsp_valid / rsp_stall   glb_pkg::rsp_item_t (kind, offset, width)
//   cfg       cfg_we                  cfg_index, cfg_data
//
// A table write is taken in the IDLE state. A lookup that needs no search
// goes from IDLE to EMIT; a search does one table read and compare per cycle
// in the SEARCH state until a hit or an empty range, and a hit then passes
// through SCALE, where its offset is multiplied, before EMIT. Reset returns
// the controller, the output valid and the configuration registers to their
// reset values; the table is not cleared. A stalled result waits in the
// output register while the next item is accepted.
// ----------------------------------------------------------------------------
module glyph_locator_binary_search_top #(
	parameter int unsigned TABLE_DEPTH = glb_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  glb_pkg::req_item_t              req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output glb_pkg::rsp_item_t              rsp,
	input  logic                            cfg_we,
	input  logic [glb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [glb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import glb_pkg::*;

	glb_cmd_t    cmd;
	glb_status_t status;

	glb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.status    (status),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	glb_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/core/glb_ctrl.sv =====
// ----------------------------------------------------------------------------
// glb_ctrl
// Sequencer for the glyph locator: accepts items, steps the search and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module glb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [0:0]          req_type,
	input  glb_pkg::glb_status_t status,
	output glb_pkg::glb_cmd_t    cmd,
	output logic                req_stall
);
	import glb_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_SCALE  = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.wr    = accept && (req_type == REQ_WRITE);
		cmd.load  = accept && (req_type == REQ_LOOKUP);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = status.need_search ? ST_SEARCH : ST_EMIT;
				end
			end
			ST_SEARCH: begin
				cmd.step = 1'b1;
				if (status.search_done) begin
					state_d = status.hit ? ST_SCALE : ST_EMIT;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = status.rsp_free;
				if (status.rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/glb_datapath.sv =====
// ----------------------------------------------------------------------------
// glb_datapath
// Configuration registers, codepoint table, classification, search bounds,
// offset multiplier and the output register of the glyph locator.
// ----------------------------------------------------------------------------
module glb_datapath #(
	parameter int unsigned TABLE_DEPTH = glb_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  glb_pkg::glb_cmd_t                    cmd,
	input  glb_pkg::req_item_t                   req,
	input  logic                                 cfg_we,
	input  logic [glb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [glb_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 rsp_stall,
	output glb_pkg::glb_status_t                 status,
	output logic                                 rsp_valid,
	output glb_pkg::rsp_item_t                   rsp
);
	import glb_pkg::*;

	localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned PROD_W = ADDR_W + 8;

	logic [ASCII_CNT_W-1:0] ascii_cnt_q;
	logic                   font_loaded_q;
	logic [WIDE_CNT_W-1:0]  wide_cnt_q;
	logic [WIDTH_W-1:0]     wide_width_q;
	logic [7:0]             stride_q;

	logic [CP_W-1:0] table_mem [TABLE_DEPTH];

	logic [CP_W-1:0]     cp_q;
	logic [CNT_W-1:0]    lo_q;
	logic [CNT_W-1:0]    hi_q;
	logic [ADDR_W-1:0]   mid_q;
	logic [CP_W-1:0]     rdata_q;
	logic [ADDR_W-1:0]   pos_q;
	logic [KIND_W-1:0]   kind_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [WIDTH_W-1:0]  width_q;
	logic                rsp_valid_q;
	rsp_item_t           rsp_q;

	logic [CP_W-1:0]     qcp;
	logic                is_narrow;
	logic                is_control;
	logic                is_repl;
	logic [KIND_W-1:0]   kind_init;
	logic [OFFSET_W-1:0] offset_init;
	logic [WIDTH_W-1:0]  width_init;
	logic [CNT_W-1:0]    hi_init;
	logic                slot_ok;

	logic                lt;
	logic                gt;
	logic [CNT_W-1:0]    lo_n;
	logic [CNT_W-1:0]    hi_n;
	logic [CNT_W:0]      sum_n;
	logic [ADDR_W-1:0]   rd_addr;
	logic [PROD_W-1:0]   prod;

	assign qcp        = req.query_codepoint;
	assign is_narrow  = qcp < CP_W'(ascii_cnt_q);
	assign is_control = qcp < CONTROL_LIMIT;
	assign is_repl    = qcp == REPLACEMENT_CP;
	assign slot_ok    = 32'(req.entry_slot) < TABLE_DEPTH;
	assign hi_init    = (32'(wide_cnt_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
		: CNT_W'(wide_cnt_q);

	always_comb begin
		kind_init   = KIND_NONE;
		offset_init = '0;
		width_init  = '0;
		if (is_narrow) begin
			width_init = NARROW_WIDTH;
			if (is_control) begin
				kind_init = KIND_CONTROL;
			end else begin
				kind_init   = KIND_ASCII;
				offset_init = OFFSET_W'({qcp, 4'b0000});
			end
		end else if (is_repl) begin
			kind_init  = KIND_REPLACEMENT;
			width_init = REPLACEMENT_WIDTH;
		end
	end

	assign lt = rdata_q < cp_q;
	assign gt = rdata_q > cp_q;

	always_comb begin
		if (cmd.load) begin
			lo_n = '0;
			hi_n = hi_init;
		end else begin
			lo_n = lt ? (CNT_W'(mid_q) + CNT_W'(1)) : lo_q;
			hi_n = gt ? CNT_W'(mid_q) : hi_q;
		end
		sum_n   = {1'b0, lo_n} + {1'b0, hi_n};
		rd_addr = ADDR_W'(sum_n >> 1);
	end

	assign prod = PROD_W'(pos_q) * PROD_W'(stride_q);

	assign status.need_search = !is_narrow && !is_repl && font_loaded_q && (wide_cnt_q != '0);
	assign status.hit         = !lt && !gt;
	assign status.search_done = (!lt && !gt) || !(lo_n < hi_n);
	assign status.rsp_free    = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_cnt_q   <= ASCII_COUNT_RST;
			font_loaded_q <= 1'b0;
			wide_cnt_q    <= '0;
			wide_width_q  <= WIDE_WIDTH_RST;
			stride_q      <= WIDE_STRIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ASCII_COUNT: ascii_cnt_q   <= cfg_data[ASCII_CNT_W-1:0];
				CFG_FONT_LOADED: font_loaded_q <= cfg_data[0];
				CFG_WIDE_COUNT:  wide_cnt_q    <= cfg_data[WIDE_CNT_W-1:0];
				CFG_WIDE_WIDTH:  wide_width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_WIDE_STRIDE: stride_q      <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && slot_ok) begin
			table_mem[ADDR_W'(req.entry_slot)] <= req.entry_codepoint;
		end
		if (cmd.load || cmd.step) begin
			rdata_q <= table_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cp_q     <= qcp;
			kind_q   <= kind_init;
			offset_q <= offset_init;
			width_q  <= width_init;
		end
		if (cmd.load || cmd.step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= rd_addr;
		end
		if (cmd.step && !lt && !gt) begin
			pos_q   <= mid_q;
			kind_q  <= KIND_WIDE;
			width_q <= wide_width_q;
		end
		if (cmd.scale) begin
			offset_q <= OFFSET_W'(prod);
		end
		if (cmd.emit) begin
			rsp_q.glyph_kind   <= kind_q;
			rsp_q.glyph_offset <= offset_q;
			rsp_q.glyph_px     <= width_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/glb_checker.sv =====
// ----------------------------------------------------------------------------
// glb_checker
// Port-level checks of the glyph locator results, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glb_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  glb_pkg::rsp_item_t rsp
);
	import glb_pkg::*;

	logic kind_control;
	logic kind_none;
	logic kind_repl;
	logic zero_offset;

	assign kind_control = rsp_valid && (rsp.glyph_kind == KIND_CONTROL);
	assign kind_none    = rsp_valid && (rsp.glyph_kind == KIND_NONE);
	assign kind_repl    = rsp_valid && (rsp.glyph_kind == KIND_REPLACEMENT);
	assign zero_offset  = rsp.glyph_offset == '0;

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`ASSERT_IMPLIES(a_control_shape, clk, arst_n, kind_control, (rsp.glyph_px == NARROW_WIDTH) && zero_offset)
	`ASSERT_IMPLIES(a_none_shape, clk, arst_n, kind_none, (rsp.glyph_px == '0) && zero_offset)
	`ASSERT_IMPLIES(a_repl_shape, clk, arst_n, kind_repl, (rsp.glyph_px == REPLACEMENT_WIDTH) && zero_offset)

endmodule

bind glyph_locator_binary_search_top glb_checker u_glb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Glyph locator testbench
// Drives table writes and codepoint lookups into the glyph locator under random
// idle and stall on both channels, with one long output hold-off. A directed
// table with hand-written answers comes first, then random phases, each with
// its own register settings and most with their own table contents: sorted,
// unsorted, full, oversized counts and extreme widths and strides. Directed
// lookups are checked field by field against their hand-written answers, the
// others against a predictor of the classification and the binary search.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import glb_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int LIMIT = 1000000;
	localparam int SETTLE = 24;

	typedef enum logic [1:0] {ROW_LOOKUP, ROW_WRITE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		req_item_t                item;
		logic [CFG_IDX_W-1:0]     reg_idx;
		logic [CFG_DATA_W-1:0]    reg_val;
		rsp_item_t                answer;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_stall;
	req_item_t              req = '0;
	logic                   rsp_valid;
	logic                   rsp_stall = 1'b0;
	rsp_item_t              rsp;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic [CP_W-1:0]        font_table [DEPTH];
	logic [ASCII_CNT_W-1:0] ascii_limit = ASCII_COUNT_RST;
	logic                   font_on = 1'b0;
	logic [WIDE_CNT_W-1:0]  entry_count = '0;
	logic [WIDTH_W-1:0]     wide_w = WIDE_WIDTH_RST;
	logic [7:0]             glyph_stride = WIDE_STRIDE_RST;

	rsp_item_t              expected_glyphs [$];
	row_t                   directed_rows [$];
	int                     errors = 0;
	int                     cycles = 0;
	logic                   quiet = 1'b0;
	logic                   hold_on = 1'b0;
	bit                     squeeze_go = 1'b0;

	glyph_locator_binary_search_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("FAIL glyph_locator_binary_search_top");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic rsp_item_t locate_glyph(input logic [CP_W-1:0] cp);
		rsp_item_t r;
		int lo;
		int hi;
		int mid;
		r = '0;
		if (cp < CP_W'(ascii_limit)) begin
			r.glyph_px = NARROW_WIDTH;
			if (cp < CONTROL_LIMIT) begin
				r.glyph_kind = KIND_CONTROL;
			end else begin
				r.glyph_kind = KIND_ASCII;
				r.glyph_offset = OFFSET_W'(cp * 16);
			end
		end else if (cp == REPLACEMENT_CP) begin
			r.glyph_kind = KIND_REPLACEMENT;
			r.glyph_px = REPLACEMENT_WIDTH;
		end else if (font_on && entry_count != '0) begin
			lo = 0;
			hi = (int'(entry_count) > DEPTH) ? DEPTH : int'(entry_count);
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (font_table[mid] < cp) begin
					lo = mid + 1;
				end else if (font_table[mid] > cp) begin
					hi = mid;
				end else begin
					r.glyph_kind = KIND_WIDE;
					r.glyph_offset = OFFSET_W'(mid * int'(glyph_stride));
					r.glyph_px = wide_w;
					break;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : rsp_check
		rsp_item_t want;
		if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			if (expected_glyphs.size() == 0) begin
				report_mismatch("result with nothing expected", int'(rsp), 0);
			end else begin
				want = expected_glyphs.pop_front();
				if (rsp.glyph_kind !== want.glyph_kind)
					report_mismatch("glyph_kind", int'(rsp.glyph_kind),
						int'(want.glyph_kind));
				if (rsp.glyph_offset !== want.glyph_offset)
					report_mismatch("glyph_offset", int'(rsp.glyph_offset),
						int'(want.glyph_offset));
				if (rsp.glyph_px !== want.glyph_px)
					report_mismatch("glyph_px", int'(rsp.glyph_px),
						int'(want.glyph_px));
			end
		end
		rsp_stall <= hold_on || (!quiet && $urandom_range(0, 99) < 24);
	end

	// The output side holds off long enough for the block to back up into its input.
	initial begin
		wait (squeeze_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (400) @(posedge clk);
		hold_on <= 1'b0;
	end

	task automatic send_item(input req_item_t it, input bit typed, input rsp_item_t answer);
		while (!quiet && $urandom_range(0, 99) < 24) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (req_stall !== 1'b0);
		if (it.req_type == REQ_LOOKUP)
			expected_glyphs.push_back(typed ? answer : locate_glyph(it.query_codepoint));
		else if (int'(it.entry_slot) < DEPTH)
			font_table[it.entry_slot] = it.entry_codepoint;
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_glyphs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_ASCII_COUNT: ascii_limit = val[ASCII_CNT_W-1:0];
			CFG_FONT_LOADED: font_on = val[0];
			CFG_WIDE_COUNT:  entry_count = val[WIDE_CNT_W-1:0];
			CFG_WIDE_WIDTH:  wide_w = val[WIDTH_W-1:0];
			CFG_WIDE_STRIDE: glyph_stride = val[7:0];
			default: ;
		endcase
	endtask

	function automatic void add_lookup(input logic [CP_W-1:0] cp, input logic [KIND_W-1:0] k,
			input logic [OFFSET_W-1:0] off, input logic [WIDTH_W-1:0] w);
		row_t r;
		r = '{kind: ROW_LOOKUP, item: '0, reg_idx: '0, reg_val: '0, answer: '0};
		r.item.req_type = REQ_LOOKUP;
		r.item.query_codepoint = cp;
		r.answer = '{glyph_kind: k, glyph_offset: off, glyph_px: w};
		directed_rows.push_back(r);
	endfunction

	function automatic void add_write(input logic [SLOT_W-1:0] slot, input logic [CP_W-1:0] cp);
		row_t r;
		r = '{kind: ROW_WRITE, item: '0, reg_idx: '0, reg_val: '0, answer: '0};
		r.item.req_type = REQ_WRITE;
		r.item.entry_slot = slot;
		r.item.entry_codepoint = cp;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		directed_rows.push_back('{kind: ROW_CFG, item: '0, reg_idx: idx, reg_val: val, answer: '0});
	endfunction

	task automatic run_phase(input int ascii, input int font, input int count, input int w,
			input int stride, input int fill, input bit sorted, input int n,
			input bit calm, input bit squeeze);
		int eff;
		int step_max;
		int slot;
		int r;
		logic [CP_W-1:0] v;
		req_item_t it;
		if (fill > 0) begin
			v = CP_W'($urandom_range(128, 1024));
			step_max = 2000000 / fill;
			if (step_max > 60000)
				step_max = 60000;
			for (int s = 0; s < fill; s++) begin
				it.req_type = REQ_WRITE;
				it.entry_slot = SLOT_W'(s);
				it.entry_codepoint = sorted ? v : CP_W'($urandom);
				it.query_codepoint = CP_W'($urandom);
				send_item(it, 1'b0, '0);
				v = v + CP_W'($urandom_range(1, step_max));
			end
		end
		wait_idle();
		write_reg(CFG_ASCII_COUNT, CFG_DATA_W'(ascii));
		write_reg(CFG_FONT_LOADED, CFG_DATA_W'(font));
		write_reg(CFG_WIDE_COUNT, CFG_DATA_W'(count));
		write_reg(CFG_WIDE_WIDTH, CFG_DATA_W'(w));
		write_reg(CFG_WIDE_STRIDE, CFG_DATA_W'(stride));
		cfg_we <= 1'b0;
		quiet <= calm;
		if (squeeze)
			squeeze_go = 1'b1;
		eff = (count > DEPTH) ? DEPTH : count;
		for (int i = 0; i < n; i++) begin
			it.req_type = REQ_LOOKUP;
			it.entry_slot = SLOT_W'($urandom);
			it.entry_codepoint = CP_W'($urandom);
			it.query_codepoint = CP_W'($urandom);
			r = $urandom_range(0, 99);
			slot = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
			if (r < 12) begin
				it.req_type = REQ_WRITE;
				if (eff < DEPTH)
					it.entry_slot = SLOT_W'($urandom_range(eff, DEPTH - 1));
				else
					it.entry_codepoint = font_table[it.entry_slot];
			end else if (r < 57 && eff > 0) begin
				it.query_codepoint = font_table[slot];
			end else if (r < 70 && eff > 0) begin
				it.query_codepoint = $urandom_range(0, 1) ? font_table[slot] + CP_W'(1)
				                                          : font_table[slot] - CP_W'(1);
			end else if (r < 80) begin
				it.query_codepoint = CP_W'($urandom_range(0, 511));
			end else if (r < 84) begin
				it.query_codepoint = REPLACEMENT_CP;
			end
			send_item(it, 1'b0, '0);
		end
	endtask

	initial begin
		add_lookup(21'h000000, KIND_CONTROL, 20'h0, 8'd8);
		add_lookup(21'h00001F, KIND_CONTROL, 20'h0, 8'd8);
		add_lookup(21'h000020, KIND_ASCII, 20'h200, 8'd8);
		add_lookup(21'h00007F, KIND_ASCII, 20'h7F0, 8'd8);
		add_lookup(21'h000080, KIND_NONE, 20'h0, 8'd0);
		add_lookup(21'h00FFFD, KIND_REPLACEMENT, 20'h0, 8'd16);
		add_lookup(21'h1FFFFF, KIND_NONE, 20'h0, 8'd0);
		add_write(12'd0, 21'h000100);
		add_write(12'd1, 21'h004E00);
		add_write(12'd2, 21'h00FFFD);
		add_write(12'd3, 21'h1FFFFF);
		add_cfg(CFG_FONT_LOADED, 13'd1);
		add_cfg(CFG_WIDE_COUNT, 13'd4);
		add_lookup(21'h004E00, KIND_WIDE, 20'd32, 8'd16);
		add_lookup(21'h1FFFFF, KIND_WIDE, 20'd96, 8'd16);
		add_lookup(21'h000100, KIND_WIDE, 20'd0, 8'd16);
		add_lookup(21'h00FFFD, KIND_REPLACEMENT, 20'h0, 8'd16);
		add_lookup(21'h004E01, KIND_NONE, 20'h0, 8'd0);
		add_cfg(CFG_WIDE_WIDTH, 13'd255);
		add_cfg(CFG_WIDE_STRIDE, 13'd255);
		add_lookup(21'h1FFFFF, KIND_WIDE, 20'd765, 8'd255);
		add_cfg(CFG_ASCII_COUNT, 13'd0);
		add_lookup(21'h000000, KIND_NONE, 20'h0, 8'd0);
		add_cfg(CFG_ASCII_COUNT, 13'd511);
		add_lookup(21'h0001FE, KIND_ASCII, 20'h1FE0, 8'd8);
		add_lookup(21'h000100, KIND_ASCII, 20'h1000, 8'd8);
		add_cfg(CFG_WIDE_COUNT, 13'd0);
		add_lookup(21'h004E00, KIND_NONE, 20'h0, 8'd0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
				cfg_we <= 1'b0;
			end else begin
				send_item(directed_rows[i].item, 1'b1, directed_rows[i].answer);
			end
		end

		run_phase(128, 1, 16, 16, 32, 16, 1'b1, 200, 1'b0, 1'b1);
		run_phase(256, 1, 4096, 255, 255, 4096, 1'b1, 150, 1'b1, 1'b0);
		run_phase(0, 1, 8191, 0, 0, 0, 1'b1, 150, 1'b0, 1'b0);
		run_phase(511, 1, 1, 8, 1, 1, 1'b1, 100, 1'b0, 1'b0);
		run_phase(32, 0, 100, 24, 72, 100, 1'b1, 100, 1'b0, 1'b0);
		run_phase(128, 1, 37, 16, 32, 37, 1'b0, 200, 1'b0, 1'b0);
		run_phase(127, 1, 4097, 16, 32, 0, 1'b1, 150, 1'b0, 1'b0);
		run_phase($urandom_range(0, 511), 1, 300, $urandom_range(0, 255),
			$urandom_range(0, 255), 300, 1'b1, 300, 1'b0, 1'b0);
		run_phase(128, 1, 2, 16, 32, 2, 1'b1, 100, 1'b0, 1'b0);

		quiet <= 1'b0;
		wait_idle();
		if (errors == 0)
			$display("PASS glyph_locator_binary_search_top");
		else
			$display("FAIL glyph_locator_binary_search_top");
		$finish;
	end

endmodule
